// ===== hw/rtl/scbp_pkg.sv =====
// Shared types, constants and class tables of the size class buffer pool.
// No dependencies; used by the pool top level.
`timescale 1ns / 1ps

package scbp_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SIZE_W      = 24;
    localparam int KB_W        = 14;
    localparam int QUOTA_W     = 13;
    localparam int PORT_HDL_W  = 13;
    localparam int PORT_CLS_W  = 3;

    localparam logic [SIZE_W-1:0] RESET_LIMIT_KB = 24'd5242880;
    localparam logic [SIZE_W-1:0] RESET_TOTAL_KB = 24'd334240;

    typedef enum logic [2:0] {
        ST_FREE      = 3'd0,
        ST_NEW       = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_LIMIT     = 3'd3,
        ST_NO_HANDLE = 3'd4
    } status_t;

    // class size in KB; zero marks an unused slot
    function automatic logic [KB_W-1:0] class_kb(input logic [3:0] slot);
        logic [KB_W-1:0] kb;
        unique case (slot)
            4'd0:    kb = 14'd4;
            4'd1:    kb = 14'd16;
            4'd2:    kb = 14'd64;
            4'd3:    kb = 14'd256;
            4'd4:    kb = 14'd1024;
            4'd5:    kb = 14'd4096;
            4'd6:    kb = 14'd8192;
            default: kb = 14'd0;
        endcase
        return kb;
    endfunction

    function automatic logic [QUOTA_W-1:0] initial_quota(input logic [3:0] slot);
        logic [QUOTA_W-1:0] q;
        unique case (slot)
            4'd0:    q = 13'd5000;
            4'd1:    q = 13'd1000;
            4'd2:    q = 13'd500;
            4'd3:    q = 13'd200;
            4'd4:    q = 13'd50;
            4'd5:    q = 13'd20;
            4'd6:    q = 13'd10;
            default: q = 13'd0;
        endcase
        return q;
    endfunction

endpackage

// ===== hw/rtl/scbp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module scbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/size_class_buffer_pool.sv =====
// Top level of the size class buffer pool: decode, class/link RAM sequencing.
// Depends on scbp_pkg and scbp_ram.
`timescale 1ns / 1ps

// Usage:
//   s_* channel takes one request beat: s_tuser[0] = mode (0 allocate,
//   1 release), s_tdata = request_size, returned_handle, returned_class.
//   m_* channel returns exactly one result beat per request:
//   m_tuser = status, m_tdata = handle, size_class.
//   cfg_* channel writes memory_limit_kb; write it only while idle.
// Sequence:
//   A request is accepted in the idle state, the class record is read from
//   the class RAM, and the result is loaded into the output register from
//   the class state. A pop from a non-empty free list needs a second
//   dependent read of the link RAM and loads the result from the link state.
//   A new request is taken only once the previous one has left these states.
// Reset:
//   All lists empty, quotas at their initial values, fresh handle counter
//   at zero, total at the initial pool sum. No clearing pass: the class RAM
//   is covered by per-class valid bits, the link RAM is only read after a push.
// Stall:
//   A finished result waits in the output register; a new request is still
//   taken, and its result waits in the block until the output frees up.

module size_class_buffer_pool #(
    parameter int HANDLE_COUNT = 8192,
    parameter int CLASS_COUNT  = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size[23:0], returned_handle[36:24],
                                   // returned_class[39:37]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // handle[12:0], size_class[15:13]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);

    localparam int HW    = $clog2(HANDLE_COUNT);
    localparam int CW    = CLASS_COUNT > 1 ? $clog2(CLASS_COUNT) : 1;
    localparam int SLOTS = 1 << CW;
    localparam int QW    = scbp_pkg::QUOTA_W;

    typedef struct packed {
        logic          head_end;
        logic [HW-1:0] head;
        logic [QW-1:0] quota;
    } class_rec_t;

    localparam int REC_W  = $bits(class_rec_t);
    localparam int LINK_W = HW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLS,
        S_LINK
    } state_t;

    state_t                       state_reg;
    logic [scbp_pkg::SIZE_W-1:0]  limit_reg;
    logic [scbp_pkg::SIZE_W-1:0]  total_kb_reg;
    logic [HW:0]                  fresh_reg;
    logic [SLOTS-1:0]             cls_valid_reg;

    logic                         mode_reg;
    logic [HW-1:0]                rh_reg;
    logic [CW-1:0]                cls_reg;
    logic                         too_large_reg;
    logic                         bad_class_reg;
    logic                         bad_handle_reg;
    class_rec_t                   rec_reg;

    logic                         m_valid_reg;
    scbp_pkg::status_t            m_status_reg;
    logic [scbp_pkg::PORT_HDL_W-1:0] m_handle_reg;
    logic [scbp_pkg::PORT_CLS_W-1:0] m_class_reg;

    // input fields
    logic                         in_mode;
    logic [scbp_pkg::SIZE_W-1:0]  in_size;
    logic [12:0]                  in_rh;
    logic [2:0]                   in_rc;

    assign in_mode = s_tuser[0];
    assign in_size = s_tdata[23:0];
    assign in_rh   = s_tdata[36:24];
    assign in_rc   = s_tdata[39:37];

    logic accept;
    logic out_free;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // smallest class that fits
    logic [3:0] fit_slot;
    logic       fit_found;
    always_comb
    begin
        fit_slot  = '0;
        fit_found = 1'b0;
        for (int c = 0; c < scbp_pkg::TABLE_SLOTS; c++)
        begin
            if (!fit_found && c < CLASS_COUNT &&
                scbp_pkg::class_kb(4'(c)) != '0 &&
                in_size <= {scbp_pkg::class_kb(4'(c)), 10'b0})
            begin
                fit_slot  = 4'(c);
                fit_found = 1'b1;
            end
        end
    end

    logic [CW-1:0] rd_cls;
    assign rd_cls = in_mode ? CW'(in_rc) : CW'(fit_slot);

    // class record RAM
    logic          cls_wr_en;
    class_rec_t    cls_wr_data;
    logic [REC_W-1:0] cls_rd_data;

    scbp_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_class_ram (
        .clk     (clk),
        .wr_en   (cls_wr_en),
        .wr_addr (cls_reg),
        .wr_data (cls_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_cls),
        .rd_data (cls_rd_data)
    );

    // a class never written reads as its reset record
    class_rec_t cur_rec;
    always_comb
    begin
        if (cls_valid_reg[cls_reg])
        begin
            cur_rec = class_rec_t'(cls_rd_data);
        end
        else
        begin
            cur_rec.head_end = 1'b1;
            cur_rec.head     = '0;
            cur_rec.quota    = scbp_pkg::initial_quota(4'(cls_reg));
        end
    end

    // free list links
    logic              link_wr_en;
    logic              link_rd_en;
    logic [LINK_W-1:0] link_rd_data;

    scbp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (HANDLE_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (rh_reg),
        .wr_data ({cur_rec.head_end, cur_rec.head}),
        .rd_en   (link_rd_en),
        .rd_addr (cur_rec.head),
        .rd_data (link_rd_data)
    );

    logic [scbp_pkg::KB_W-1:0]  grow_kb;
    logic [scbp_pkg::SIZE_W:0]  grow_sum;
    logic                       limit_hit;
    logic                       fresh_out;
    assign grow_kb   = scbp_pkg::class_kb(4'(cls_reg));
    assign grow_sum  = {1'b0, total_kb_reg} + (scbp_pkg::SIZE_W + 1)'(grow_kb);
    assign limit_hit = grow_sum >= {1'b0, limit_reg};
    assign fresh_out = 32'(fresh_reg) >= HANDLE_COUNT;

    // action taken in the class cycle
    logic              any_err;
    logic              do_release;
    logic              do_pop;
    logic              do_quota;
    logic              do_grow;
    scbp_pkg::status_t res_status;
    assign any_err    = bad_class_reg || bad_handle_reg || too_large_reg;
    assign do_release = !any_err && mode_reg;
    assign do_pop     = !any_err && !mode_reg && !cur_rec.head_end;
    assign do_quota   = !any_err && !mode_reg && cur_rec.head_end &&
                        cur_rec.quota != '0 && !fresh_out;
    assign do_grow    = !any_err && !mode_reg && cur_rec.head_end &&
                        cur_rec.quota == '0 && !limit_hit && !fresh_out;

    always_comb
    begin
        priority if (bad_class_reg || too_large_reg)
            res_status = scbp_pkg::ST_TOO_LARGE;
        else if (bad_handle_reg)
            res_status = scbp_pkg::ST_NO_HANDLE;
        else if (mode_reg)
            res_status = scbp_pkg::ST_FREE;
        else if (cur_rec.quota == '0 && limit_hit)
            res_status = scbp_pkg::ST_LIMIT;
        else if (fresh_out)
            res_status = scbp_pkg::ST_NO_HANDLE;
        else
            res_status = scbp_pkg::ST_NEW;
    end

    logic cls_fire;
    logic link_fire;
    logic out_load;
    assign cls_fire   = (state_reg == S_CLS) && !do_pop && out_free;
    assign link_fire  = (state_reg == S_LINK) && out_free;
    assign out_load   = cls_fire || link_fire;
    assign link_wr_en = cls_fire && do_release;
    assign link_rd_en = (state_reg == S_CLS) && do_pop;

    always_comb
    begin
        cls_wr_data = cur_rec;
        cls_wr_en   = 1'b0;
        if (link_fire)
        begin
            cls_wr_en            = 1'b1;
            cls_wr_data.head_end = link_rd_data[HW];
            cls_wr_data.head     = link_rd_data[HW-1:0];
        end
        else if (cls_fire && do_release)
        begin
            cls_wr_en            = 1'b1;
            cls_wr_data.head_end = 1'b0;
            cls_wr_data.head     = rh_reg;
        end
        else if (cls_fire && do_quota)
        begin
            cls_wr_en         = 1'b1;
            cls_wr_data.quota = cur_rec.quota - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= scbp_pkg::RESET_LIMIT_KB;
            total_kb_reg   <= scbp_pkg::RESET_TOTAL_KB;
            fresh_reg      <= '0;
            cls_valid_reg  <= '0;
            mode_reg       <= 1'b0;
            rh_reg         <= '0;
            cls_reg        <= '0;
            too_large_reg  <= 1'b0;
            bad_class_reg  <= 1'b0;
            bad_handle_reg <= 1'b0;
            rec_reg        <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= scbp_pkg::ST_FREE;
            m_handle_reg   <= '0;
            m_class_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cls_wr_en)
            begin
                cls_valid_reg[cls_reg] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= in_mode;
                        rh_reg         <= HW'(in_rh);
                        cls_reg        <= rd_cls;
                        too_large_reg  <= !in_mode && !fit_found;
                        bad_class_reg  <= in_mode && 32'(in_rc) >= CLASS_COUNT;
                        bad_handle_reg <= in_mode && 32'(in_rh) >= HANDLE_COUNT;
                        state_reg      <= S_CLS;
                    end
                end
                S_CLS:
                begin
                    if (do_pop)
                    begin
                        rec_reg   <= cur_rec;
                        state_reg <= S_LINK;
                    end
                    else if (out_free)
                    begin
                        m_status_reg <= res_status;
                        if (do_release)
                        begin
                            m_handle_reg <= scbp_pkg::PORT_HDL_W'(rh_reg);
                            m_class_reg  <= scbp_pkg::PORT_CLS_W'(cls_reg);
                        end
                        else if (do_quota || do_grow)
                        begin
                            m_handle_reg <= scbp_pkg::PORT_HDL_W'(fresh_reg[HW-1:0]);
                            m_class_reg  <= scbp_pkg::PORT_CLS_W'(cls_reg);
                            fresh_reg    <= fresh_reg + 1'b1;
                        end
                        else
                        begin
                            m_handle_reg <= '0;
                            m_class_reg  <= '0;
                        end
                        if (do_grow)
                        begin
                            total_kb_reg <= grow_sum[scbp_pkg::SIZE_W-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_LINK:
                begin
                    if (out_free)
                    begin
                        m_status_reg <= scbp_pkg::ST_FREE;
                        m_handle_reg <= scbp_pkg::PORT_HDL_W'(rec_reg.head);
                        m_class_reg  <= scbp_pkg::PORT_CLS_W'(cls_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_class_reg, m_handle_reg};
    assign m_tuser  = m_status_reg;

    // fresh handles never run past the handle space
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fresh_reg) <= HANDLE_COUNT)
        else $error("fresh handle counter past handle count");

    // a new-buffer result always consumes exactly one fresh handle
    a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_fire && (do_quota || do_grow)) |=> fresh_reg == $past(fresh_reg) + 1'b1)
        else $error("fresh handle not advanced on new buffer");

    // the memory total moves only on growth past the initial quota
    a_total_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLS || !do_grow || !out_free) |=> $stable(total_kb_reg))
        else $error("total KB changed without growth");

    // a link read is only issued for a non-empty list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> !rec_reg.head_end)
        else $error("link cycle on an empty list");

    // no new request while a result is still pending in the block
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CLS) && !s_tready)
        else $error("request not sequenced through class cycle");

endmodule
